@@ rtl/core/dsa_pkg.sv @@
// Shared types, constants and the microcode ROM for the decimal scale aligner.
package dsa_pkg;

   localparam int WORD_W        = 32;
   localparam int MANT_W        = 3 * WORD_W;
   localparam int SCALE_W       = 5;
   localparam int SCALE_CAP_DEF = 28;
   localparam int SUM_W         = MANT_W + 4;

   localparam int CHUNK_W       = 16;
   localparam int CHUNKS        = MANT_W / CHUNK_W;
   localparam int CNT_W         = $clog2(CHUNKS);
   localparam int REM_W         = 4;
   localparam int CUR_W         = REM_W + CHUNK_W;
   localparam int PROD_W        = 2 * CUR_W;
   localparam int RECIP_SHIFT   = 23;
   localparam logic [CUR_W-1:0] RECIP      = CUR_W'(((1 << RECIP_SHIFT) + 9) / 10);
   localparam logic [REM_W-1:0] HALF_DIGIT = REM_W'(5);

   localparam int PC_W = 3;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type STEP_WAIT  = PC_W'(0);
   localparam pc_type STEP_MUL   = PC_W'(1);
   localparam pc_type STEP_CHECK = PC_W'(2);
   localparam pc_type STEP_DIV   = PC_W'(3);
   localparam pc_type STEP_ROUND = PC_W'(4);
   localparam pc_type STEP_EMIT  = PC_W'(5);

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL,
      OP_DIV_INIT,
      OP_DIV,
      OP_ROUND,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      CND_ALWAYS,
      CND_NO_REQ,
      CND_MUL_OK,
      CND_ALIGNED,
      CND_DIV_MORE,
      CND_OUT_BLOCKED
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
      pc_type   next;
   } ctrl_type;

   typedef struct packed {
      logic req_fire;
      logic mul_ok;
      logic aligned;
      logic div_more;
      logic out_blocked;
   } status_type;

   function automatic ctrl_type ucode_rom(input pc_type pc);
      ctrl_type word;
      unique case (pc)
         STEP_WAIT:  word = '{OP_LOAD,     CND_NO_REQ,      STEP_WAIT,  STEP_MUL};
         STEP_MUL:   word = '{OP_MUL,      CND_MUL_OK,      STEP_MUL,   STEP_CHECK};
         STEP_CHECK: word = '{OP_DIV_INIT, CND_ALIGNED,     STEP_EMIT,  STEP_DIV};
         STEP_DIV:   word = '{OP_DIV,      CND_DIV_MORE,    STEP_DIV,   STEP_ROUND};
         STEP_ROUND: word = '{OP_ROUND,    CND_ALWAYS,      STEP_CHECK, STEP_CHECK};
         STEP_EMIT:  word = '{OP_EMIT,     CND_OUT_BLOCKED, STEP_EMIT,  STEP_WAIT};
         default:    word = '{OP_NOP,      CND_ALWAYS,      STEP_WAIT,  STEP_WAIT};
      endcase
      return word;
   endfunction

endpackage

@@ rtl/core/dsa_ucode.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module dsa_ucode (
   input  logic                clock,
   input  logic                reset,
   input  dsa_pkg::status_type status,
   output dsa_pkg::ctrl_type   ctrl
);
   import dsa_pkg::*;

   pc_type pc_ff;
   pc_type pc_in;
   logic   taken;

   always_comb begin
      ctrl = ucode_rom(pc_ff);
      case (ctrl.cond)
         CND_ALWAYS:      taken = 1'b1;
         CND_NO_REQ:      taken = !status.req_fire;
         CND_MUL_OK:      taken = status.mul_ok;
         CND_ALIGNED:     taken = status.aligned;
         CND_DIV_MORE:    taken = status.div_more;
         CND_OUT_BLOCKED: taken = status.out_blocked;
         default:         taken = 1'b1;
      endcase
      pc_in = taken ? ctrl.target : ctrl.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ rtl/core/decimal_scale_align.sv @@
// Top level: decimal scale aligner datapath, microcode sequencer and result register.
// Sequence: after the accepting edge, multiply steps on the lower-scale operand, then a scale check;
// each divide step is six 16-bit reciprocal-multiply chunks, a round and a scale check.
// One item at a time: the next request is taken the cycle after the result is loaded, and
// loading the result waits while rsp_stall holds a previous result.
// Reset (synchronous, active high) returns the sequencer to its wait step and clears rsp_valid.
module decimal_scale_align #(
   parameter int SCALE_CAP = dsa_pkg::SCALE_CAP_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [dsa_pkg::WORD_W-1:0]  req_a_word_low,
   input  logic [dsa_pkg::WORD_W-1:0]  req_a_word_mid,
   input  logic [dsa_pkg::WORD_W-1:0]  req_a_word_high,
   input  logic [dsa_pkg::SCALE_W-1:0] req_a_scale,
   input  logic                        req_a_negative,
   input  logic [dsa_pkg::WORD_W-1:0]  req_b_word_low,
   input  logic [dsa_pkg::WORD_W-1:0]  req_b_word_mid,
   input  logic [dsa_pkg::WORD_W-1:0]  req_b_word_high,
   input  logic [dsa_pkg::SCALE_W-1:0] req_b_scale,
   input  logic                        req_b_negative,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [dsa_pkg::WORD_W-1:0]  rsp_out_a_low,
   output logic [dsa_pkg::WORD_W-1:0]  rsp_out_a_mid,
   output logic [dsa_pkg::WORD_W-1:0]  rsp_out_a_high,
   output logic                        rsp_out_a_negative,
   output logic [dsa_pkg::WORD_W-1:0]  rsp_out_b_low,
   output logic [dsa_pkg::WORD_W-1:0]  rsp_out_b_mid,
   output logic [dsa_pkg::WORD_W-1:0]  rsp_out_b_high,
   output logic                        rsp_out_b_negative,
   output logic [dsa_pkg::SCALE_W-1:0] rsp_common_scale
);
   import dsa_pkg::*;

   localparam logic [SCALE_W-1:0] MAX_S = SCALE_W'(SCALE_CAP);

   ctrl_type   ctrl;
   status_type status;

   logic [MANT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [SCALE_W-1:0] lo_s_ff, lo_s_in, hi_s_ff, hi_s_in;
   logic               a_is_lo_ff, a_is_lo_in;
   logic               a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   chunk_ff, chunk_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [MANT_W-1:0]  rsp_a_ff, rsp_a_in, rsp_b_ff, rsp_b_in;
   logic               rsp_a_neg_ff, rsp_a_neg_in, rsp_b_neg_ff, rsp_b_neg_in;
   logic [SCALE_W-1:0] rsp_scale_ff, rsp_scale_in;

   logic [SCALE_W-1:0] sa_sat, sb_sat;
   logic [MANT_W-1:0]  a_mant, b_mant;
   logic               a_lower;
   logic [SUM_W-1:0]   add_x, add_y, sum;
   logic               mul_fit;
   logic [CUR_W-1:0]   cur, q10, rem_full;
   logic [PROD_W-1:0]  prod;
   logic [CHUNK_W-1:0] quot;
   logic               round_up;

   dsa_ucode u_ucode (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign req_stall = (ctrl.op != OP_LOAD);

   always_comb begin
      sa_sat  = (req_a_scale > MAX_S) ? MAX_S : req_a_scale;
      sb_sat  = (req_b_scale > MAX_S) ? MAX_S : req_b_scale;
      a_mant  = {req_a_word_high, req_a_word_mid, req_a_word_low};
      b_mant  = {req_b_word_high, req_b_word_mid, req_b_word_low};
      a_lower = (sa_sat < sb_sat);

      // shared adder: m*8 + m*2 for multiply, m + 1 for rounding
      if (ctrl.op == OP_ROUND) begin
         add_x = {4'b0000, hi_ff};
         add_y = SUM_W'(1);
      end else begin
         add_x = {1'b0, lo_ff, 3'b000};
         add_y = {3'b000, lo_ff, 1'b0};
      end
      sum     = add_x + add_y;
      mul_fit = (sum[SUM_W-1:MANT_W] == '0);

      // one 16-bit chunk of long division by ten
      cur      = {rem_ff, hi_ff[MANT_W-1 -: CHUNK_W]};
      prod     = {{CUR_W{1'b0}}, cur} * {{CUR_W{1'b0}}, RECIP};
      quot     = prod[RECIP_SHIFT +: CHUNK_W];
      q10      = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
      rem_full = cur - q10;

      round_up = (rem_ff > HALF_DIGIT) || ((rem_ff == HALF_DIGIT) && hi_ff[0]);

      status.req_fire    = req_valid && !req_stall;
      status.mul_ok      = (lo_s_ff < hi_s_ff) && (lo_s_ff < MAX_S) && mul_fit;
      status.aligned     = (lo_s_ff == hi_s_ff);
      status.div_more    = (chunk_ff != CNT_W'(CHUNKS - 1));
      status.out_blocked = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      lo_s_in    = lo_s_ff;
      hi_s_in    = hi_s_ff;
      a_is_lo_in = a_is_lo_ff;
      a_neg_in   = a_neg_ff;
      b_neg_in   = b_neg_ff;
      rem_in     = rem_ff;
      chunk_in   = chunk_ff;
      case (ctrl.op)
         OP_LOAD: begin
            if (status.req_fire) begin
               a_is_lo_in = a_lower;
               lo_in      = a_lower ? a_mant : b_mant;
               hi_in      = a_lower ? b_mant : a_mant;
               lo_s_in    = a_lower ? sa_sat : sb_sat;
               hi_s_in    = a_lower ? sb_sat : sa_sat;
               a_neg_in   = req_a_negative;
               b_neg_in   = req_b_negative;
            end
         end
         OP_MUL: begin
            if (status.mul_ok) begin
               lo_in   = sum[MANT_W-1:0];
               lo_s_in = lo_s_ff + SCALE_W'(1);
            end
         end
         OP_DIV_INIT: begin
            rem_in   = '0;
            chunk_in = '0;
         end
         OP_DIV: begin
            hi_in    = {hi_ff[MANT_W-CHUNK_W-1:0], quot};
            rem_in   = rem_full[REM_W-1:0];
            chunk_in = chunk_ff + CNT_W'(1);
         end
         OP_ROUND: begin
            if (round_up) begin
               hi_in = sum[MANT_W-1:0];
            end
            hi_s_in = hi_s_ff - SCALE_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_a_neg_in = rsp_a_neg_ff;
      rsp_b_neg_in = rsp_b_neg_ff;
      rsp_scale_in = rsp_scale_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((ctrl.op == OP_EMIT) && !status.out_blocked) begin
         rsp_valid_in = 1'b1;
         rsp_a_in     = a_is_lo_ff ? lo_ff : hi_ff;
         rsp_b_in     = a_is_lo_ff ? hi_ff : lo_ff;
         rsp_a_neg_in = a_neg_ff;
         rsp_b_neg_in = b_neg_ff;
         rsp_scale_in = lo_s_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      lo_s_ff      <= lo_s_in;
      hi_s_ff      <= hi_s_in;
      a_is_lo_ff   <= a_is_lo_in;
      a_neg_ff     <= a_neg_in;
      b_neg_ff     <= b_neg_in;
      rem_ff       <= rem_in;
      chunk_ff     <= chunk_in;
      rsp_a_ff     <= rsp_a_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_a_neg_ff <= rsp_a_neg_in;
      rsp_b_neg_ff <= rsp_b_neg_in;
      rsp_scale_ff <= rsp_scale_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_a_low      = rsp_a_ff[0 +: WORD_W];
   assign rsp_out_a_mid      = rsp_a_ff[WORD_W +: WORD_W];
   assign rsp_out_a_high     = rsp_a_ff[2*WORD_W +: WORD_W];
   assign rsp_out_a_negative = rsp_a_neg_ff;
   assign rsp_out_b_low      = rsp_b_ff[0 +: WORD_W];
   assign rsp_out_b_mid      = rsp_b_ff[WORD_W +: WORD_W];
   assign rsp_out_b_high     = rsp_b_ff[2*WORD_W +: WORD_W];
   assign rsp_out_b_negative = rsp_b_neg_ff;
   assign rsp_common_scale   = rsp_scale_ff;

endmodule

@@ rtl/core/dsa_checker.sv @@
// Port-level checker for the decimal scale aligner, bound to the top level.
module dsa_checker #(
   parameter int SCALE_CAP = dsa_pkg::SCALE_CAP_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [dsa_pkg::WORD_W-1:0]  rsp_out_a_low,
   input logic [dsa_pkg::WORD_W-1:0]  rsp_out_b_low,
   input logic [dsa_pkg::SCALE_W-1:0] rsp_common_scale
);
   import dsa_pkg::*;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_common_scale)
         && $stable(rsp_out_a_low) && $stable(rsp_out_b_low))
      else $error("stalled result beat changed");

   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_common_scale <= SCALE_W'(SCALE_CAP))
      else $error("common scale above maximum");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous beat in flight");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("wrong state after reset");

endmodule

bind decimal_scale_align dsa_checker #(.SCALE_CAP(SCALE_CAP)) u_dsa_checker (.*);
